// ----- rtl/core/cfe_pkg.sv -----
// Shared types and constants for the Cantor function evaluator.
`timescale 1ns / 1ps

package cfe_pkg;

	// Payload widths fixed by the word formats
	localparam int unsigned X_W        = 33;
	localparam int unsigned CDF_W      = 34;
	// Result scale: the value is cdf_value / 2^OUT_BITS
	localparam int unsigned OUT_BITS   = 33;

	// Default configuration of the evaluator
	localparam int unsigned LEVELS_DEF        = 32;
	localparam int unsigned FRACTION_BITS_DEF = 32;

	// Result for an argument at or above one: exactly 2^OUT_BITS
	localparam logic [CDF_W-1:0] CDF_ONE = {1'b1, {(CDF_W-1){1'b0}}};

	// Control bits that travel with each word down the pipeline
	typedef struct packed {
		logic valid;
		logic done;
		logic hit;
	} ctl_t;

endpackage

// ----- rtl/core/cfe_in_if.sv -----
// Argument channel: valid/ready handshake carrying one fixed-point argument.
`timescale 1ns / 1ps

interface cfe_in_if;
	logic                       valid;
	logic                       ready;
	logic [cfe_pkg::X_W-1:0]    x_value;

	modport source (output valid, output x_value, input ready);
	modport sink   (input valid, input x_value, output ready);
endinterface

// ----- rtl/core/cfe_out_if.sv -----
// Result channel: valid/ready handshake carrying one Cantor function value.
`timescale 1ns / 1ps

interface cfe_out_if;
	logic                       valid;
	logic                       ready;
	logic [cfe_pkg::CDF_W-1:0]  cdf_value;
	logic                       hit_middle_third;

	modport source (output valid, output cdf_value, output hit_middle_third, input ready);
	modport sink   (input valid, input cdf_value, input hit_middle_third, output ready);
endinterface

// ----- rtl/core/cantor_function_eval.sv -----
// Cantor function evaluator: top level with the level-per-stage pipeline.
//
// Usage: an argument word arrives on the arg channel as x_value / 2^FRACTION_BITS;
// zero gives 0 and one or more gives 1.0. Each word yields exactly one result
// word on the res channel: cdf_value / 2^33, and hit_middle_third set when the
// expansion stopped inside a middle third (clear at the level cap or at an
// endpoint). Both channels use valid/ready; a word moves when both are high.
// The pipeline has one entry stage that classifies the argument,
// one register stage per ternary level (a triple-by-shift-add and two compares
// each), and one output stage that adds the trailing bit at the level cap.
// Throughput is one word per cycle while the receiver is ready; it is set by
// the single shift-add and two compares in each level stage.
// When the receiver holds ready low while a result is shown, the whole
// pipeline freezes and arg.ready drops; nothing is lost or repeated, and the
// pipeline accepts words again as soon as the result is taken. With the
// output register empty, arg.ready is high.
// Reset (arst_n low) clears every valid bit at once; the block is ready to
// take words as soon as reset is released.
`timescale 1ns / 1ps

module cantor_function_eval #(
	parameter int unsigned LEVELS        = cfe_pkg::LEVELS_DEF,
	parameter int unsigned FRACTION_BITS = cfe_pkg::FRACTION_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	cfe_in_if.sink    arg,
	cfe_out_if.source res
);
	import cfe_pkg::*;

	logic                     en;
	ctl_t                     lvl_ctl [0:LEVELS];
	logic [FRACTION_BITS-1:0] lvl_r   [0:LEVELS-1];
	logic [CDF_W-1:0]         lvl_acc [0:LEVELS];

	// All stages advance together unless a result waits on a stalled receiver.
	assign en        = !res.valid || res.ready;
	assign arg.ready = en;

	cfe_entry #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_entry (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_d (arg.valid),
		.x_d     (arg.x_value),
		.ctl_q   (lvl_ctl[0]),
		.r_q     (lvl_r[0]),
		.acc_q   (lvl_acc[0])
	);

	// One register stage per ternary level.
	generate
		for (genvar k = 0; k < LEVELS; k++) begin : g_level
			if (k < LEVELS - 1) begin : g_mid
				cfe_level #(
					.FRACTION_BITS (FRACTION_BITS),
					.LEVEL         (k)
				) u_level (
					.clk    (clk),
					.arst_n (arst_n),
					.en     (en),
					.ctl_d  (lvl_ctl[k]),
					.r_d    (lvl_r[k]),
					.acc_d  (lvl_acc[k]),
					.ctl_q  (lvl_ctl[k+1]),
					.r_q    (lvl_r[k+1]),
					.acc_q  (lvl_acc[k+1])
				);
			end else begin : g_last
				cfe_level #(
					.FRACTION_BITS (FRACTION_BITS),
					.LEVEL         (k)
				) u_level (
					.clk    (clk),
					.arst_n (arst_n),
					.en     (en),
					.ctl_d  (lvl_ctl[k]),
					.r_d    (lvl_r[k]),
					.acc_d  (lvl_acc[k]),
					.ctl_q  (lvl_ctl[k+1]),
					.r_q    (),
					.acc_q  (lvl_acc[k+1])
				);
			end
		end
	endgenerate

	cfe_finish #(
		.LEVELS (LEVELS)
	) u_finish (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_d   (lvl_ctl[LEVELS]),
		.acc_d   (lvl_acc[LEVELS]),
		.valid_q (res.valid),
		.cdf_q   (res.cdf_value),
		.hit_q   (res.hit_middle_third)
	);

`ifndef SYNTHESIS
	// An empty output register never holds back the argument channel.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res.valid |-> arg.ready)
		else $error("argument channel stalled with an empty output register");

	// A middle-third stop always carries its trailing bit and stays below one.
	a_hit_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.hit_middle_third) |-> (!res.cdf_value[CDF_W-1] &&
			(res.cdf_value != '0)))
		else $error("middle-third result out of range");

	// A result of one is exact and never flagged as a middle-third stop.
	a_one_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.cdf_value[CDF_W-1]) |-> ((res.cdf_value == CDF_ONE) &&
			!res.hit_middle_third))
		else $error("result at one is malformed");
`endif

endmodule

// ----- rtl/core/cfe_entry.sv -----
// Entry stage: classifies the argument and loads the working fraction.
`timescale 1ns / 1ps

module cfe_entry #(
	parameter int unsigned FRACTION_BITS = cfe_pkg::FRACTION_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        valid_d,
	input  logic [cfe_pkg::X_W-1:0]     x_d,
	output cfe_pkg::ctl_t               ctl_q,
	output logic [FRACTION_BITS-1:0]    r_q,
	output logic [cfe_pkg::CDF_W-1:0]   acc_q
);
	import cfe_pkg::*;

	logic                     x_ge_one;
	logic                     x_zero;
	logic [FRACTION_BITS-1:0] r_d;
	ctl_t                     ctl_s1;
	logic [FRACTION_BITS-1:0] r_s1;
	logic [CDF_W-1:0]         acc_s1;

	// Split the argument into its integer part and the fraction below one.
	generate
		if (FRACTION_BITS < X_W) begin : g_narrow
			assign x_ge_one = |x_d[X_W-1:FRACTION_BITS];
			assign r_d      = x_d[FRACTION_BITS-1:0];
		end else if (FRACTION_BITS == X_W) begin : g_equal
			assign x_ge_one = 1'b0;
			assign r_d      = x_d;
		end else begin : g_wide
			assign x_ge_one = 1'b0;
			assign r_d      = {{(FRACTION_BITS-X_W){1'b0}}, x_d};
		end
	endgenerate

	assign x_zero = (x_d == '0);

	// Control bits of the stage; zero and at-or-above-one arguments finish here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid <= valid_d;
			ctl_s1.done  <= x_zero | x_ge_one;
			ctl_s1.hit   <= 1'b0;
		end
	end

	// Fraction and the fixed result of a word that is already finished.
	always_ff @(posedge clk) begin
		if (en) begin
			r_s1   <= r_d;
			acc_s1 <= x_ge_one ? CDF_ONE : '0;
		end
	end

	assign ctl_q = ctl_s1;
	assign r_q   = r_s1;
	assign acc_q = acc_s1;

endmodule

// ----- rtl/core/cfe_level.sv -----
// One level of the ternary expansion: triples the fraction and emits one digit.
`timescale 1ns / 1ps

module cfe_level #(
	parameter int unsigned FRACTION_BITS = cfe_pkg::FRACTION_BITS_DEF,
	parameter int unsigned LEVEL         = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  cfe_pkg::ctl_t               ctl_d,
	input  logic [FRACTION_BITS-1:0]    r_d,
	input  logic [cfe_pkg::CDF_W-1:0]   acc_d,
	output cfe_pkg::ctl_t               ctl_q,
	output logic [FRACTION_BITS-1:0]    r_q,
	output logic [cfe_pkg::CDF_W-1:0]   acc_q
);
	import cfe_pkg::*;

	localparam int unsigned T_W = FRACTION_BITS + 2;
	localparam logic [T_W-1:0] ONE_T = {{(T_W-1){1'b0}}, 1'b1} << FRACTION_BITS;
	localparam logic [T_W-1:0] TWO_T = ONE_T << 1;
	// Digit of this level lands in this bit of the result
	localparam int unsigned DIGIT_BIT = OUT_BITS - 1 - LEVEL;
	localparam logic [CDF_W-1:0] DIGIT_MASK = {{(CDF_W-1){1'b0}}, 1'b1} << DIGIT_BIT;

	logic [T_W-1:0]           t;
	logic                     below;
	logic                     above;
	ctl_t                     ctl_n;
	logic [CDF_W-1:0]         acc_n;
	ctl_t                     ctl_s1;
	logic [FRACTION_BITS-1:0] r_s1;
	logic [CDF_W-1:0]         acc_s1;

	// Exact tripling by shift and add, then the two third boundaries.
	assign t     = {2'b00, r_d} + {1'b0, r_d, 1'b0};
	assign below = (t < ONE_T);
	assign above = (t > TWO_T);

	// A word still open either takes a digit or stops in the middle third,
	// where the trailing one bit is placed at this level's position.
	always_comb begin
		ctl_n       = ctl_d;
		acc_n       = acc_d;
		if (!ctl_d.done) begin
			if (above) begin
				acc_n = acc_d | DIGIT_MASK;
			end else if (!below) begin
				acc_n     = acc_d | DIGIT_MASK;
				ctl_n.done = 1'b1;
				ctl_n.hit  = 1'b1;
			end
		end
	end

	// Control bits of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_n;
		end
	end

	// Above two thirds the new fraction is t minus two, which only drops the top bit.
	always_ff @(posedge clk) begin
		if (en) begin
			r_s1   <= t[FRACTION_BITS-1:0];
			acc_s1 <= acc_n;
		end
	end

	assign ctl_q = ctl_s1;
	assign r_q   = r_s1;
	assign acc_q = acc_s1;

endmodule

// ----- rtl/core/cfe_finish.sv -----
// Output stage: closes words that ran to the level cap and holds the result word.
`timescale 1ns / 1ps

module cfe_finish #(
	parameter int unsigned LEVELS = cfe_pkg::LEVELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  cfe_pkg::ctl_t               ctl_d,
	input  logic [cfe_pkg::CDF_W-1:0]   acc_d,
	output logic                        valid_q,
	output logic [cfe_pkg::CDF_W-1:0]   cdf_q,
	output logic                        hit_q
);
	import cfe_pkg::*;

	// Trailing one bit for a word that used every level
	localparam int unsigned CAP_BIT = OUT_BITS - 1 - LEVELS;
	localparam logic [CDF_W-1:0] CAP_MASK = {{(CDF_W-1){1'b0}}, 1'b1} << CAP_BIT;

	logic             valid_s1;
	logic [CDF_W-1:0] cdf_s1;
	logic             hit_s1;

	// Valid bit of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= ctl_d.valid;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (en) begin
			cdf_s1 <= ctl_d.done ? acc_d : (acc_d | CAP_MASK);
			hit_s1 <= ctl_d.hit;
		end
	end

	assign valid_q = valid_s1;
	assign cdf_q   = cdf_s1;
	assign hit_q   = hit_s1;

endmodule
